// ===== src/assert_macros.svh =====
// Assertion macros shared by the RTL of the instruction template encoder.
// Needs a clock named clk and an active-low reset named rst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, switched off while reset is held.
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Clocked assertion that is also checked while reset is held.
`define ASSERT_CLK_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// ===== src/xite_pkg.sv =====
// Package of the x86 instruction template encoder: operation codes,
// encoding byte constants and the request and result structures. No dependencies.
package xite_pkg;

  // Operation codes of the request.
  localparam logic [4:0] OP_MOVRR      = 5'd0;
  localparam logic [4:0] OP_LOAD       = 5'd1;
  localparam logic [4:0] OP_STORE      = 5'd2;
  localparam logic [4:0] OP_STORESPILL = 5'd3;
  localparam logic [4:0] OP_LOADSPILL  = 5'd4;
  localparam logic [4:0] OP_PUSH       = 5'd5;
  localparam logic [4:0] OP_POP        = 5'd6;
  localparam logic [4:0] OP_CALL       = 5'd7;
  localparam logic [4:0] OP_JCC        = 5'd8;
  localparam logic [4:0] OP_MOVIMM32AX = 5'd9;
  localparam logic [4:0] OP_TEST       = 5'd10;
  localparam logic [4:0] OP_JMP        = 5'd11;
  localparam logic [4:0] OP_RET        = 5'd12;
  localparam logic [4:0] OP_MOVIMM64   = 5'd13;
  localparam logic [4:0] OP_MOVSLOT    = 5'd14;
  localparam logic [4:0] OP_MOVSTK     = 5'd15;
  localparam logic [4:0] OP_XCHGSTK    = 5'd16;
  localparam logic [4:0] OP_LOADBASE   = 5'd17;
  localparam logic [4:0] OP_STOREBASE  = 5'd18;

  // Prefix and opcode bytes.
  localparam logic [7:0] REX_W       = 8'h48;
  localparam logic [7:0] REX_R       = 8'h44;
  localparam logic [7:0] REX_X       = 8'h42;
  localparam logic [7:0] REX_B       = 8'h41;
  localparam logic [7:0] SIB_SP_BASE = 8'h24;
  localparam logic [7:0] OPC_MOV_LD  = 8'h8B;
  localparam logic [7:0] OPC_MOV_ST  = 8'h89;
  localparam logic [7:0] OPC_XCHG    = 8'h87;
  localparam logic [7:0] OPC_TEST    = 8'h85;
  localparam logic [7:0] OPC_PUSH    = 8'h50;
  localparam logic [7:0] OPC_POP     = 8'h58;
  localparam logic [7:0] OPC_CALL    = 8'hE8;
  localparam logic [7:0] OPC_JMP     = 8'hE9;
  localparam logic [7:0] OPC_RET     = 8'hC3;
  localparam logic [7:0] OPC_ESC     = 8'h0F;
  localparam logic [7:0] OPC_JCC     = 8'h80;
  localparam logic [7:0] OPC_MOV_IMM = 8'hC7;
  localparam logic [7:0] OPC_MOV_AX  = 8'hB8;
  localparam logic [7:0] MODRM_AX    = 8'hC0;

  // Largest disp8 value plus one.
  localparam logic [31:0] DISP8_LIMIT = 32'h80;

  // Mod field values of ModR/M.
  localparam logic [1:0] MOD_DISP8  = 2'b01;
  localparam logic [1:0] MOD_DISP32 = 2'b10;
  localparam logic [1:0] MOD_REG    = 2'b11;

  // Base low bits that call for a SIB byte (SP or R12).
  localparam logic [2:0] BASE_SP = 3'd4;

  localparam int unsigned CODE_BYTES = 12;

  typedef struct packed {
    logic [4:0]  op;
    logic [3:0]  reg_first;
    logic [3:0]  reg_second;
    logic [3:0]  cond_code;
    logic [31:0] offset;
    logic [63:0] immediate;
  } xite_req_t;

  typedef struct packed {
    logic [63:0] code_low;
    logic [31:0] code_high;
    logic [3:0]  code_length;
    logic        fault;
  } xite_res_t;

endpackage

// ===== src/xite_encode.sv =====
// Combinational instruction encoder: decodes one request into prefix, opcode,
// ModR/M, SIB, displacement and immediate pieces and packs them. Uses xite_pkg.
module xite_encode
  import xite_pkg::*;
(
  input  xite_req_t req,
  input  logic      long_mode,
  output xite_res_t res
);

  logic        use1, use2, bad;
  logic        rex_w, rr_v, rb_v;
  logic [3:0]  rr, rb;
  logic [7:0]  rex_byte;
  logic        has_rex;
  logic [1:0]  opc_len;
  logic [7:0]  opc0, opc1;
  logic        has_modrm, has_sib, has_mem, mem_d8, is_load;
  logic [7:0]  modrm;
  logic [3:0]  mem_base;
  logic [2:0]  mem_reg;
  logic [31:0] eff_off;
  logic [2:0]  disp_len;
  logic [31:0] disp;
  logic [3:0]  imm_len;
  logic [31:0] slot_r1, slot_r2;
  logic [95:0] acc;
  logic [3:0]  pos;

  // Operand offset of a spill slot or base slot: register number times slot size.
  assign slot_r1 = long_mode ? {25'd0, req.reg_first, 3'd0}  : {26'd0, req.reg_first, 2'd0};
  assign slot_r2 = long_mode ? {25'd0, req.reg_second, 3'd0} : {26'd0, req.reg_second, 2'd0};

  always_comb begin
    use1      = 1'b0;
    use2      = 1'b0;
    bad       = 1'b0;
    rex_w     = 1'b0;
    rr_v      = 1'b0;
    rb_v      = 1'b0;
    rr        = 4'd0;
    rb        = 4'd0;
    opc_len   = 2'd1;
    opc0      = 8'd0;
    opc1      = 8'd0;
    has_modrm = 1'b0;
    modrm     = 8'd0;
    has_sib   = 1'b0;
    has_mem   = 1'b0;
    mem_d8    = 1'b0;
    mem_base  = 4'd0;
    mem_reg   = 3'd0;
    eff_off   = 32'd0;
    is_load   = 1'b0;
    disp_len  = 3'd0;
    disp      = 32'd0;
    imm_len   = 4'd0;

    case (req.op)
      OP_MOVRR: begin
        use1      = 1'b1;
        use2      = 1'b1;
        rex_w     = 1'b1;
        rr_v      = 1'b1;
        rr        = req.reg_first;
        rb_v      = 1'b1;
        rb        = req.reg_second;
        opc0      = OPC_MOV_ST;
        has_modrm = 1'b1;
        modrm     = {MOD_REG, req.reg_first[2:0], req.reg_second[2:0]};
      end
      OP_LOAD, OP_STORE, OP_STORESPILL, OP_LOADSPILL: begin
        use1     = 1'b1;
        use2     = 1'b1;
        is_load  = (req.op == OP_LOAD) || (req.op == OP_LOADSPILL);
        eff_off  = (req.op == OP_LOAD) || (req.op == OP_STORE) ? req.offset : slot_r1;
        rex_w    = 1'b1;
        rr_v     = 1'b1;
        rr       = req.reg_first;
        rb_v     = 1'b1;
        rb       = req.reg_second;
        opc0     = is_load ? OPC_MOV_LD : OPC_MOV_ST;
        has_mem  = 1'b1;
        mem_base = req.reg_second;
        mem_reg  = req.reg_first[2:0];
        mem_d8   = eff_off < DISP8_LIMIT;
      end
      OP_LOADBASE, OP_STOREBASE: begin
        use2     = 1'b1;
        bad      = long_mode;
        is_load  = req.op == OP_LOADBASE;
        eff_off  = slot_r2;
        rex_w    = 1'b1;
        rr_v     = 1'b1;
        rb_v     = 1'b1;
        rb       = req.reg_second;
        opc0     = is_load ? OPC_MOV_LD : OPC_MOV_ST;
        has_mem  = 1'b1;
        mem_base = req.reg_second;
        mem_d8   = eff_off < DISP8_LIMIT;
      end
      OP_PUSH, OP_POP: begin
        use1 = 1'b1;
        rb_v = 1'b1;
        rb   = req.reg_first;
        opc0 = (req.op == OP_PUSH ? OPC_PUSH : OPC_POP) | {5'd0, req.reg_first[2:0]};
      end
      OP_TEST: begin
        use1      = 1'b1;
        rex_w     = 1'b1;
        rr_v      = 1'b1;
        rr        = req.reg_first;
        rb_v      = 1'b1;
        rb        = req.reg_first;
        opc0      = OPC_TEST;
        has_modrm = 1'b1;
        modrm     = {MOD_REG, req.reg_first[2:0], req.reg_first[2:0]};
      end
      OP_CALL: begin
        opc0     = OPC_CALL;
        disp_len = 3'd4;
      end
      OP_JMP: begin
        opc0     = OPC_JMP;
        disp_len = 3'd4;
      end
      OP_JCC: begin
        opc_len  = 2'd2;
        opc0     = OPC_ESC;
        opc1     = OPC_JCC | {4'd0, req.cond_code};
        disp_len = 3'd4;
      end
      OP_RET: begin
        opc0 = OPC_RET;
      end
      OP_MOVIMM32AX: begin
        imm_len = 4'd4;
        if (long_mode) begin
          rex_w     = 1'b1;
          opc0      = OPC_MOV_IMM;
          has_modrm = 1'b1;
          modrm     = MODRM_AX;
        end else begin
          opc0 = OPC_MOV_AX;
        end
      end
      OP_MOVIMM64: begin
        bad     = !long_mode;
        rex_w   = 1'b1;
        opc0    = OPC_MOV_AX;
        imm_len = 4'd8;
      end
      OP_MOVSLOT: begin
        use2     = 1'b1;
        rex_w    = 1'b1;
        rb_v     = 1'b1;
        rb       = req.reg_second;
        opc0     = OPC_MOV_IMM;
        has_mem  = 1'b1;
        mem_base = req.reg_second;
        eff_off  = req.offset;
        imm_len  = 4'd4;
      end
      OP_MOVSTK, OP_XCHGSTK: begin
        // Stack slot below the frame: [esp + (7 - reg) * 4], always disp8.
        use1     = 1'b1;
        bad      = long_mode;
        opc0     = req.op == OP_XCHGSTK ? OPC_XCHG : OPC_MOV_ST;
        has_mem  = 1'b1;
        mem_base = {1'b0, BASE_SP};
        mem_d8   = 1'b1;
        eff_off  = {27'd0, ~req.reg_first[2:0], 2'd0};
      end
      default: begin
        bad = 1'b1;
      end
    endcase

    if (has_mem) begin
      has_modrm = 1'b1;
      modrm     = {mem_d8 ? MOD_DISP8 : MOD_DISP32, mem_reg, mem_base[2:0]};
      has_sib   = mem_base[2:0] == BASE_SP;
      disp_len  = mem_d8 ? 3'd1 : 3'd4;
      disp      = eff_off;
    end

    // Registers of eight and above do not exist in x86-32.
    if (!long_mode && ((use1 && req.reg_first[3]) || (use2 && req.reg_second[3]))) begin
      bad = 1'b1;
    end
  end

  always_comb begin
    rex_byte = 8'd0;
    if (rex_w) begin
      rex_byte = rex_byte | REX_W;
    end
    if (rr_v && rr[3]) begin
      rex_byte = rex_byte | REX_R;
    end
    if (rb_v && rb[3]) begin
      rex_byte = rex_byte | REX_B;
    end
  end

  assign has_rex = long_mode && (rex_byte != 8'd0);

  // Pieces are laid down one after the other from byte 0 upwards.
  always_comb begin
    acc = 96'd0;
    pos = 4'd0;
    if (has_rex) begin
      acc = acc | (96'(rex_byte) << {pos, 3'b000});
      pos = pos + 4'd1;
    end
    acc = acc | (96'(opc0) << {pos, 3'b000});
    pos = pos + 4'd1;
    if (opc_len == 2'd2) begin
      acc = acc | (96'(opc1) << {pos, 3'b000});
      pos = pos + 4'd1;
    end
    if (has_modrm) begin
      acc = acc | (96'(modrm) << {pos, 3'b000});
      pos = pos + 4'd1;
    end
    if (has_sib) begin
      acc = acc | (96'(SIB_SP_BASE) << {pos, 3'b000});
      pos = pos + 4'd1;
    end
    if (disp_len == 3'd4) begin
      acc = acc | (96'(disp) << {pos, 3'b000});
    end else begin
      acc = acc | (96'(disp[7:0]) << {pos, 3'b000});
    end
    pos = pos + {1'b0, disp_len};
    // Operations without an immediate leave the bytes past the end at zero.
    if (imm_len == 4'd8) begin
      acc = acc | (96'(req.immediate) << {pos, 3'b000});
    end else if (imm_len == 4'd4) begin
      acc = acc | (96'(req.immediate[31:0]) << {pos, 3'b000});
    end
    pos = pos + imm_len;
  end

  always_comb begin
    if (bad) begin
      res.code_low    = 64'd0;
      res.code_high   = 32'd0;
      res.code_length = 4'd0;
      res.fault       = 1'b1;
    end else begin
      res.code_low    = acc[63:0];
      res.code_high   = acc[95:64];
      res.code_length = pos;
      res.fault       = 1'b0;
    end
  end

endmodule

// ===== src/x86_instruction_template_encoder_core.sv =====
// Top level of the x86 instruction template encoder: stream ports, mode
// register, input register and result register. Uses xite_pkg, xite_encode.
//
// The block turns one instruction request per transaction into x86 machine
// code of up to twelve bytes, packed little-endian with byte 0 in the lowest
// bits, together with its length. Bytes at and beyond the length read as zero.
// A request that names an unknown operation, an operation that the current
// mode lacks, or a register of eight or above in x86-32 mode comes back with
// the fault flag in out_tuser set, length 0 and no code bytes. Branch and call
// displacements are emitted as zero. The mode register (cfg_wr_data, reset to
// x86-64) is written by cfg_wr_en and must only be changed while no
// transaction is in flight. Each request is held in the input register while
// the encode logic works on it and is loaded into the result register once
// that register is free, from where it is presented at the output. Both
// registers advance independently, so one transaction is accepted every
// cycle as long as the result side keeps taking them; the input register goes
// on accepting while a finished result waits at the output, and in_tready
// only drops when both registers are occupied and out_tready is low.
`include "assert_macros.svh"

module x86_instruction_template_encoder_core
  import xite_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  // Mode register write port.
  input  logic         cfg_wr_en,
  input  logic         cfg_wr_data,
  // Request stream.
  input  logic         in_tvalid,
  output logic         in_tready,
  // in_tdata fields from bit 0 up: op[4:0], reg_first[8:5], reg_second[12:9],
  // cond_code[16:13], offset[48:17], immediate[112:49], zero padding.
  input  logic [119:0] in_tdata,
  // Result stream.
  output logic         out_tvalid,
  input  logic         out_tready,
  // out_tdata fields from bit 0 up: code_low[63:0], code_high[95:64],
  // code_length[99:96], zero padding.
  output logic [103:0] out_tdata,
  // out_tuser fields from bit 0 up: fault[0].
  output logic         out_tuser
);

  logic      long_mode_r;
  logic      s1_valid_r, s1_valid_nxt;
  xite_req_t s1_req_r;
  logic      out_valid_r, out_valid_nxt;
  xite_res_t out_res_r;
  xite_res_t enc_res;
  xite_req_t in_req;
  logic      s2_ready;
  logic      in_take;

  // Unpack the incoming transaction; padding bits are ignored.
  assign in_req.op         = in_tdata[4:0];
  assign in_req.reg_first  = in_tdata[8:5];
  assign in_req.reg_second = in_tdata[12:9];
  assign in_req.cond_code  = in_tdata[16:13];
  assign in_req.offset     = in_tdata[48:17];
  assign in_req.immediate  = in_tdata[112:49];

  // The result register can load when it is empty or being emptied.
  assign s2_ready  = !out_valid_r || out_tready;
  assign in_tready = !s1_valid_r || s2_ready;
  assign in_take   = in_tvalid && in_tready;

  always_comb begin
    if (in_take) begin
      s1_valid_nxt = 1'b1;
    end else if (s2_ready) begin
      s1_valid_nxt = 1'b0;
    end else begin
      s1_valid_nxt = s1_valid_r;
    end
    out_valid_nxt = s2_ready ? s1_valid_r : out_valid_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      long_mode_r <= 1'b1;
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        long_mode_r <= cfg_wr_data;
      end
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers carry no reset.
  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_req_r <= in_req;
    end
    if (s2_ready && s1_valid_r) begin
      out_res_r <= enc_res;
    end
  end

  xite_encode u_encode (
    .req       (s1_req_r),
    .long_mode (long_mode_r),
    .res       (enc_res)
  );

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {4'd0, out_res_r.code_length, out_res_r.code_high, out_res_r.code_low};
  assign out_tuser  = out_res_r.fault;

  `ASSERT_CLK(a_fault_empty, out_valid_r && out_res_r.fault |-> out_res_r.code_length == 4'd0 && out_res_r.code_low == 64'd0, "faulting result carries code bytes")
  `ASSERT_CLK(a_len_max, out_valid_r |-> out_res_r.code_length <= 4'(CODE_BYTES), "code length above twelve bytes")
  `ASSERT_CLK(a_ready_full, !in_tready |-> s1_valid_r && out_valid_r && !out_tready, "input stalled with room in the pipeline")
  `ASSERT_CLK_ALWAYS(a_reset_state, !rst_n |=> long_mode_r && !s1_valid_r && !out_valid_r, "reset did not restore x86-64 mode and empty pipeline")

endmodule
